[rtl/hcic_pkg.sv]
// shared constants, config register indexes and crc helper for the hash chain insert unit
package hcic_pkg;

  typedef enum logic [1:0] {
    CFG_LEVEL     = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_HASH_MASK = 2'd2,
    CFG_WIN_MASK  = 2'd3
  } cfg_index_e;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned PosW      = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned HashMaskW = 16;
  localparam int unsigned WinMaskW  = 15;
  localparam int unsigned QueueDepth = 4;

  localparam logic [LevelW-1:0]    LevelReset     = 4'd6;
  localparam logic [LevelW-1:0]    ThresholdReset = 4'd5;
  localparam logic [HashMaskW-1:0] HashMaskReset  = 16'hFFFF;
  localparam logic [WinMaskW-1:0]  WinMaskReset   = 15'h7FFF;

  localparam logic [WordW-1:0] ThreeByteMask = 32'h00FF_FFFF;
  localparam logic [WordW-1:0] Crc32cPoly    = 32'h82F6_3B78;

  // crc32c of a word with only bit idx set, zero start, no final inversion
  function automatic logic [WordW-1:0] crc_col(input int unsigned idx);
    logic [WordW-1:0] c;
    c = WordW'(1) << idx;
    for (int b = 0; b < WordW; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ Crc32cPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/hcic_fifo.sv]
// short item queue between the front and back parts
module hcic_fifo
  import hcic_pkg::*;
#(
  parameter int unsigned WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(QueueDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/hcic_front.sv]
// front part: config registers, item accept and crc32c bucket hashing
module hcic_front
  import hcic_pkg::*;
#(
  parameter int unsigned HASH_BITS   = 16,
  parameter int unsigned WINDOW_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [PosW-1:0]      position_i,
  input  logic [WordW-1:0]     next_bytes_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 clearing_i,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output logic [1+WINDOW_BITS+HASH_BITS+PosW-1:0] push_data_o
);

  logic [LevelW-1:0]    level_q;
  logic [LevelW-1:0]    threshold_q;
  logic [HashMaskW-1:0] hash_mask_q;
  logic [WinMaskW-1:0]  win_mask_q;

  logic [WordW-1:0]       word;
  logic [WordW-1:0]       terms [WordW];
  logic [WordW-1:0]       crc;
  logic [HASH_BITS-1:0]   bucket;
  logic [WINDOW_BITS-1:0] link;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LevelReset;
      threshold_q <= ThresholdReset;
      hash_mask_q <= HashMaskReset;
      win_mask_q  <= WinMaskReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LEVEL:     level_q     <= cfg_data_i[LevelW-1:0];
        CFG_THRESHOLD: threshold_q <= cfg_data_i[LevelW-1:0];
        CFG_HASH_MASK: hash_mask_q <= cfg_data_i[HashMaskW-1:0];
        CFG_WIN_MASK:  win_mask_q  <= cfg_data_i[WinMaskW-1:0];
        default: ;
      endcase
    end
  end

  assign word = (level_q >= threshold_q) ? (next_bytes_i & ThreeByteMask) : next_bytes_i;

  for (genvar g = 0; g < WordW; g++) begin : g_crc
    localparam logic [WordW-1:0] Col = crc_col(g);
    assign terms[g] = word[g] ? Col : '0;
  end

  always_comb begin
    crc = '0;
    for (int i = 0; i < WordW; i++) begin
      crc = crc ^ terms[i];
    end
  end

  assign bucket = crc[HASH_BITS-1:0] & hash_mask_q[HASH_BITS-1:0];
  assign link   = position_i[WINDOW_BITS-1:0] & win_mask_q[WINDOW_BITS-1:0];

  assign busy        = clearing_i || queue_full_i;
  assign push_o      = start && !busy;
  assign push_data_o = {last_i, link, bucket, position_i};

endmodule

[rtl/hcic_back.sv]
// back part: head table clear, head read-modify-write and chain link write
module hcic_back
  import hcic_pkg::*;
#(
  parameter int unsigned HASH_BITS   = 16,
  parameter int unsigned WINDOW_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1+WINDOW_BITS+HASH_BITS+PosW-1:0] head_data_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 result_valid_o,
  output logic [PosW-1:0]      prior_head_o
);

  localparam int unsigned HeadDepth = 2 ** HASH_BITS;
  localparam int unsigned LinkDepth = 2 ** WINDOW_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READ,
    ST_WRITE
  } state_e;

  state_e                 state_q;
  logic [HASH_BITS-1:0]   clr_cnt_q;
  logic                   result_valid_q;
  logic [PosW-1:0]        prior_head_q;

  logic [PosW-1:0]        heads [HeadDepth];
  logic [PosW-1:0]        links [LinkDepth];
  logic [PosW-1:0]        head_rdata_q;

  logic [PosW-1:0]        item_pos;
  logic [HASH_BITS-1:0]   item_bucket;
  logic [WINDOW_BITS-1:0] item_link;
  logic                   item_last;
  logic                   head_re, upd_we, head_we;
  logic [HASH_BITS-1:0]   head_waddr;
  logic [PosW-1:0]        head_wdata;

  assign {item_last, item_link, item_bucket, item_pos} = head_data_i;

  assign head_re    = (state_q == ST_READ) && !empty_i;
  assign upd_we     = (state_q == ST_WRITE) && (head_rdata_q != item_pos);
  assign head_we    = (state_q == ST_CLEAR) || upd_we;
  assign head_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : item_bucket;
  assign head_wdata = (state_q == ST_CLEAR) ? '0 : item_pos;

  assign pop_o          = (state_q == ST_WRITE);
  assign clearing_o     = (state_q == ST_CLEAR);
  assign result_valid_o = result_valid_q;
  assign prior_head_o   = prior_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_cnt_q      <= '0;
      result_valid_q <= 1'b0;
      prior_head_q   <= '0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + HASH_BITS'(1);
          if (clr_cnt_q == '1) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (!empty_i) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          result_valid_q <= item_last;
          prior_head_q   <= head_rdata_q;
          state_q        <= ST_READ;
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      heads[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rdata_q <= heads[item_bucket];
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      links[item_link] <= head_rdata_q;
    end
  end

endmodule

[rtl/hash_chain_insert_crc32c_unit.sv]
// top level of the crc32c hash chain insert unit
//
//   channel   signals                                        handshake
//   item in   start, busy, position_i, next_bytes_i, last_i  taken when start && !busy
//   result    result_valid_o, prior_head_o                   one-cycle strobe
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i  valid && ready
//
// in the back part each item takes a head read, then a head and link write through the
// single write port of the head table (both skipped when the old head equals its position);
// the next item is read only after the last one is written
// an item with last_i set strobes its result in the cycle right after the edge that pops it
// after reset all 2**HASH_BITS head table entries are swept to zero, with busy high
// busy also rises while the four-entry queue is full; results cannot be held off
module hash_chain_insert_crc32c_unit
  import hcic_pkg::*;
#(
  parameter int unsigned HASH_BITS   = 16,
  parameter int unsigned WINDOW_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [PosW-1:0]      position_i,
  input  logic [WordW-1:0]     next_bytes_i,
  input  logic                 last_i,
  output logic                 result_valid_o,
  output logic [PosW-1:0]      prior_head_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned EntryW = 1 + WINDOW_BITS + HASH_BITS + PosW;

  logic              push, pop, empty, full, clearing;
  logic [EntryW-1:0] push_data, head_data;

  hcic_front #(
    .HASH_BITS  (HASH_BITS),
    .WINDOW_BITS(WINDOW_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .position_i  (position_i),
    .next_bytes_i(next_bytes_i),
    .last_i      (last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clearing_i  (clearing),
    .queue_full_i(full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  hcic_fifo #(
    .WIDTH(EntryW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_data_o(head_data),
    .empty_o    (empty),
    .full_o     (full)
  );

  hcic_back #(
    .HASH_BITS  (HASH_BITS),
    .WINDOW_BITS(WINDOW_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_data_i   (head_data),
    .empty_i       (empty),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .result_valid_o(result_valid_o),
    .prior_head_o  (prior_head_o)
  );

endmodule

[rtl/hcic_checker.sv]
// port-level checks for the hash chain insert unit and their bind
module hcic_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic cfg_ready_o
);

  // head table sweep keeps items out during and right after reset
  a_busy_in_reset: assert property (@(posedge clk_i) !rst_ni |-> busy)
    else $error("busy low during reset");

  a_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> busy)
    else $error("busy low right after reset");

  // each item passes a read state and a write state, so strobes never touch
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back to back result strobes");

  // a result needs an accepted item, so none strobes right after reset
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !result_valid_o)
    else $error("result right after reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind hash_chain_insert_crc32c_unit hcic_checker u_hcic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .cfg_ready_o   (cfg_ready_o)
);
